FILE: src/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types, constants and fixed-point helpers for the particle Euler
// step pipeline.
// ----------------------------------------------------------------------------
package pes_pkg;

  // Q format and field widths
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FACT_W    = 17;
  localparam int unsigned IMASS_W   = 31;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned WIDE_W    = 2 * DATA_W + 1;

  // Six stages per axis plus the ground/output stage
  localparam int unsigned AXIS_STG  = 6;
  localparam int unsigned STAGES    = AXIS_STG + 1;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [DATA_W:0]   fix_ext_t;
  typedef logic [FACT_W-1:0]        fact_t;
  typedef logic [IMASS_W-1:0]       mult_t;

  localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_TIME_STEP = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_GROUND    = 3'd2,
    REG_BOUNCE    = 3'd3,
    REG_FRICTION  = 3'd4
  } pes_reg_t;

  // Register reset values
  localparam fact_t RST_TIME_STEP = 17'd1092;
  localparam fact_t RST_DAMPING   = 17'd65470;
  localparam fix_t  RST_GROUND    = '0;
  localparam fact_t RST_BOUNCE    = 17'd13107;
  localparam fact_t RST_FRICTION  = 17'd62259;

  typedef struct packed {
    fact_t time_step;
    fact_t damping_factor;
    fix_t  ground_level;
    fact_t bounce_factor;
    fact_t friction_factor;
  } pes_cfg_t;

  // Stage load enables handed to each axis
  typedef struct packed {
    logic [AXIS_STG-1:0] ld;
  } pes_ctl_t;

  function automatic fix_ext_t sext(input fix_t x);
    return {x[DATA_W-1], x};
  endfunction

  function automatic mult_t fact(input fact_t k);
    return {{(IMASS_W-FACT_W){1'b0}}, k};
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic fix_t sat_wide(input logic signed [WIDE_W-1:0] x);
    if (x[WIDE_W-1:DATA_W-1] == {(WIDE_W-DATA_W+1){x[WIDE_W-1]}}) begin
      return x[DATA_W-1:0];
    end
    return x[WIDE_W-1] ? FIX_MIN : FIX_MAX;
  endfunction

  // x times unsigned factor, floor shift by FRAC_BITS, saturate
  function automatic fix_t mulq(input fix_ext_t x, input mult_t k);
    logic signed [WIDE_W-1:0] prod;
    prod = WIDE_W'(x) * WIDE_W'($signed({1'b0, k}));
    return sat_wide(prod >>> FRAC_BITS);
  endfunction

  // Saturating add
  function automatic fix_t sat_add(input fix_t a, input fix_t b);
    fix_ext_t s;
    s = sext(a) + sext(b);
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? FIX_MIN : FIX_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

FILE: src/pes_axis.sv
// ----------------------------------------------------------------------------
// pes_axis
// Six-stage velocity/position update for one axis: dt*f, times inverse mass,
// add to velocity, damping, dt*v, add to position. Original p and v ride
// along for the fixed-particle bypass.
// ----------------------------------------------------------------------------
module pes_axis (
  input  logic              clk,
  input  pes_pkg::pes_ctl_t ctl,
  input  pes_pkg::pes_cfg_t cfg,
  input  pes_pkg::fix_t     p,
  input  pes_pkg::fix_t     v,
  input  pes_pkg::fix_t     f,
  input  pes_pkg::mult_t    w,
  output pes_pkg::fix_t     p1,
  output pes_pkg::fix_t     v2,
  output pes_pkg::fix_t     orig_p,
  output pes_pkg::fix_t     orig_v
);

  pes_pkg::fix_t op_r [pes_pkg::AXIS_STG];
  pes_pkg::fix_t ov_r [pes_pkg::AXIS_STG];
  pes_pkg::fix_t a_r, b_r, v1_r, v2_r, t_r, v2d_r, p1_r, v2o_r;

  // original position/velocity shift line
  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      op_r[0] <= p;
      ov_r[0] <= v;
    end
    for (int k = 1; k < pes_pkg::AXIS_STG; k++) begin
      if (ctl.ld[k]) begin
        op_r[k] <= op_r[k-1];
        ov_r[k] <= ov_r[k-1];
      end
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      a_r <= pes_pkg::mulq(pes_pkg::sext(f), pes_pkg::fact(cfg.time_step));
    end
    if (ctl.ld[1]) begin
      b_r <= pes_pkg::mulq(pes_pkg::sext(a_r), w);
    end
    if (ctl.ld[2]) begin
      v1_r <= pes_pkg::sat_add(ov_r[1], b_r);
    end
    if (ctl.ld[3]) begin
      v2_r <= pes_pkg::mulq(pes_pkg::sext(v1_r), pes_pkg::fact(cfg.damping_factor));
    end
    if (ctl.ld[4]) begin
      t_r   <= pes_pkg::mulq(pes_pkg::sext(v2_r), pes_pkg::fact(cfg.time_step));
      v2d_r <= v2_r;
    end
    if (ctl.ld[5]) begin
      p1_r  <= pes_pkg::sat_add(op_r[4], t_r);
      v2o_r <= v2d_r;
    end
  end

  assign p1     = p1_r;
  assign v2     = v2o_r;
  assign orig_p = op_r[pes_pkg::AXIS_STG-1];
  assign orig_v = ov_r[pes_pkg::AXIS_STG-1];

endmodule

FILE: src/particle_euler_step_ground_top.sv
// ----------------------------------------------------------------------------
// particle_euler_step_ground_top
// Semi-implicit Euler step of one particle with a ground plane, Q16.16.
// ----------------------------------------------------------------------------
// One particle word enters per clock while in_ready is high and passes
// through six register stages per axis (one multiply or saturating add each)
// followed by the ground-contact stage, which is the output register.
// Throughput is one word per cycle as long as out_ready is
// high; in_ready follows the stage occupancy and out_ready combinationally,
// so a stalled output fills bubbles before holding off the input. Registers
// are written through the cfg port at any time (cfg_ready is always high)
// and must only change while no word is in flight.
module particle_euler_step_ground_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pes_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pes_pkg::DATA_W-1:0]    cfg_data,
  // particle input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [pes_pkg::DATA_W-1:0] in_px,
  input  logic signed [pes_pkg::DATA_W-1:0] in_py,
  input  logic signed [pes_pkg::DATA_W-1:0] in_pz,
  input  logic signed [pes_pkg::DATA_W-1:0] in_vx,
  input  logic signed [pes_pkg::DATA_W-1:0] in_vy,
  input  logic signed [pes_pkg::DATA_W-1:0] in_vz,
  input  logic signed [pes_pkg::DATA_W-1:0] in_fx,
  input  logic signed [pes_pkg::DATA_W-1:0] in_fy,
  input  logic signed [pes_pkg::DATA_W-1:0] in_fz,
  input  logic [pes_pkg::IMASS_W-1:0]   in_inverse_mass,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [pes_pkg::DATA_W-1:0] out_new_px,
  output logic signed [pes_pkg::DATA_W-1:0] out_new_py,
  output logic signed [pes_pkg::DATA_W-1:0] out_new_pz,
  output logic signed [pes_pkg::DATA_W-1:0] out_new_vx,
  output logic signed [pes_pkg::DATA_W-1:0] out_new_vy,
  output logic signed [pes_pkg::DATA_W-1:0] out_new_vz,
  output logic                          out_is_fixed,
  output logic                          out_ground_contact
);

  localparam int unsigned LAST = pes_pkg::STAGES - 1;

  pes_pkg::pes_cfg_t cfg_r;
  logic [pes_pkg::STAGES-1:0]   vld_r;
  logic [pes_pkg::STAGES-1:0]   rdy;
  logic [pes_pkg::AXIS_STG-1:0] fix_r;
  pes_pkg::mult_t               w0_r;
  pes_pkg::pes_ctl_t            ctl;

  pes_pkg::fix_t pin [3];
  pes_pkg::fix_t vin [3];
  pes_pkg::fix_t fin [3];
  pes_pkg::fix_t p1 [3];
  pes_pkg::fix_t v2 [3];
  pes_pkg::fix_t op [3];
  pes_pkg::fix_t ov [3];

  pes_pkg::fix_t px_r, py_r, pz_r, vx_r, vy_r, vz_r;
  logic          is_fixed_r, contact_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step       <= pes_pkg::RST_TIME_STEP;
      cfg_r.damping_factor  <= pes_pkg::RST_DAMPING;
      cfg_r.ground_level    <= pes_pkg::RST_GROUND;
      cfg_r.bounce_factor   <= pes_pkg::RST_BOUNCE;
      cfg_r.friction_factor <= pes_pkg::RST_FRICTION;
    end else if (cfg_valid) begin
      unique case (pes_pkg::pes_reg_t'(cfg_index))
        pes_pkg::REG_TIME_STEP: cfg_r.time_step       <= cfg_data[pes_pkg::FACT_W-1:0];
        pes_pkg::REG_DAMPING:   cfg_r.damping_factor  <= cfg_data[pes_pkg::FACT_W-1:0];
        pes_pkg::REG_GROUND:    cfg_r.ground_level    <= cfg_data;
        pes_pkg::REG_BOUNCE:    cfg_r.bounce_factor   <= cfg_data[pes_pkg::FACT_W-1:0];
        pes_pkg::REG_FRICTION:  cfg_r.friction_factor <= cfg_data[pes_pkg::FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage readiness: a stage loads when empty or when the next one moves
  always_comb begin
    rdy[LAST] = !vld_r[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];
  assign ctl.ld   = rdy[pes_pkg::AXIS_STG-1:0];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < pes_pkg::STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // inverse mass and fixed flag
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      w0_r     <= in_inverse_mass;
      fix_r[0] <= (in_inverse_mass == '0);
    end
    for (int k = 1; k < pes_pkg::AXIS_STG; k++) begin
      if (rdy[k]) begin
        fix_r[k] <= fix_r[k-1];
      end
    end
  end

  // per-axis datapaths
  assign pin[0] = in_px;
  assign pin[1] = in_py;
  assign pin[2] = in_pz;
  assign vin[0] = in_vx;
  assign vin[1] = in_vy;
  assign vin[2] = in_vz;
  assign fin[0] = in_fx;
  assign fin[1] = in_fy;
  assign fin[2] = in_fz;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    pes_axis u_axis (
      .clk    (clk),
      .ctl    (ctl),
      .cfg    (cfg_r),
      .p      (pin[i]),
      .v      (vin[i]),
      .f      (fin[i]),
      .w      (w0_r),
      .p1     (p1[i]),
      .v2     (v2[i]),
      .orig_p (op[i]),
      .orig_v (ov[i])
    );
  end

  // ground contact and output register
  logic     fixed_in;
  logic     contact_nxt;
  pes_pkg::fix_ext_t neg_vy;
  pes_pkg::fix_t     bounce_vy, fric_vx, fric_vz;

  always_comb begin
    fixed_in    = fix_r[pes_pkg::AXIS_STG-1];
    contact_nxt = !fixed_in && (p1[1] < cfg_r.ground_level);
    neg_vy      = -pes_pkg::sext(v2[1]);
    bounce_vy   = pes_pkg::mulq(neg_vy, pes_pkg::fact(cfg_r.bounce_factor));
    fric_vx     = pes_pkg::mulq(pes_pkg::sext(v2[0]), pes_pkg::fact(cfg_r.friction_factor));
    fric_vz     = pes_pkg::mulq(pes_pkg::sext(v2[2]), pes_pkg::fact(cfg_r.friction_factor));
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      is_fixed_r <= fixed_in;
      contact_r  <= contact_nxt;
      if (fixed_in) begin
        px_r <= op[0];
        py_r <= op[1];
        pz_r <= op[2];
        vx_r <= ov[0];
        vy_r <= ov[1];
        vz_r <= ov[2];
      end else if (contact_nxt) begin
        px_r <= p1[0];
        py_r <= cfg_r.ground_level;
        pz_r <= p1[2];
        vx_r <= fric_vx;
        vy_r <= v2[1][pes_pkg::DATA_W-1] ? bounce_vy : v2[1];
        vz_r <= fric_vz;
      end else begin
        px_r <= p1[0];
        py_r <= p1[1];
        pz_r <= p1[2];
        vx_r <= v2[0];
        vy_r <= v2[1];
        vz_r <= v2[2];
      end
    end
  end

  assign out_valid          = vld_r[LAST];
  assign out_new_px         = px_r;
  assign out_new_py         = py_r;
  assign out_new_pz         = pz_r;
  assign out_new_vx         = vx_r;
  assign out_new_vy         = vy_r;
  assign out_new_vz         = vz_r;
  assign out_is_fixed       = is_fixed_r;
  assign out_ground_contact = contact_r;

  // checks
  a_fixed_no_contact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_fixed && out_ground_contact))
    else $error("fixed particle flagged with ground contact");

  a_above_ground: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_fixed) |-> (out_new_py >= cfg_r.ground_level))
    else $error("moving particle left below ground");

  a_contact_vy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ground_contact) |-> !out_new_vy[pes_pkg::DATA_W-1])
    else $error("vertical velocity still downward after contact");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input held off while output not stalled");

endmodule
